### rtl/core/ffa_pkg.sv
// Shared types and constants of the first-fit free-list allocator.
package ffa_pkg;

    localparam int unsigned MAX_REGIONS_DEF = 256;

    localparam logic [1:0] REQ_ALLOC    = 2'd0;
    localparam logic [1:0] REQ_FREE     = 2'd1;
    localparam logic [1:0] REQ_ALLOC_4K = 2'd2;
    localparam logic [1:0] REQ_FREE_4K  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_LOST  = 2'd2;

    localparam logic [31:0] ROUND_ADD  = 32'h0000_0fff;
    localparam logic [31:0] ROUND_MASK = 32'hffff_f000;

    typedef struct packed {
        logic [31:0] start;
        logic [31:0] len;
    } t_entry;

endpackage

### rtl/core/ffa_table.sv
// Region table memory: one write port, one registered read port.
module ffa_table #(
    parameter int unsigned DEPTH = ffa_pkg::MAX_REGIONS_DEF,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  ffa_pkg::t_entry i_wdata,
    input  logic            i_re,
    input  logic [AW-1:0]   i_raddr,
    output ffa_pkg::t_entry o_rdata
);

    logic [31:0] mem_start [DEPTH];
    logic [31:0] mem_len   [DEPTH];
    ffa_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem_start[i_waddr] <= i_wdata.start;
            mem_len[i_waddr]   <= i_wdata.len;
        end
        if (i_re) begin
            r_rdata.start <= mem_start[i_raddr];
            r_rdata.len   <= mem_len[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/first_fit_free_list_allocator.sv
// Top level of the first-fit free-list allocator with coalescing.
// Usage:
// Input channel (i_in_valid / o_in_stall) carries one request: type, address, size.
// Output channel (o_out_valid / i_out_stall) returns one result per request: address,
// status, saturating free total and the lost-free statistics.
// A request is taken only while the sequencer is idle; it then scans the region
// table, which sits in a single-port-read memory, one entry per cycle, pipelined
// against the registered read port of that memory.
// Each request passes through a scan to the first hit (or to the end of the table),
// an update, a table shift for an insert or a removal, and a response; the shift
// moves one entry at a time through the single read port of the table memory.
// Requests do not overlap: the next one is taken only once the sequencer is idle again.
// The finished result sits in an output register, so the next request is taken
// while the receiver stalls; a second result waits in the sequencer until the
// output register frees up.
// Reset clears the entry count, free total and lost statistics; the table memory
// itself needs no clearing, since entries at or above the count are never read.
module first_fit_free_list_allocator #(
    parameter int unsigned MAX_REGIONS = ffa_pkg::MAX_REGIONS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_req_type,
    input  logic [31:0] i_region_addr,
    input  logic [31:0] i_region_size,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_alloc_addr,
    output logic [1:0]  o_status,
    output logic [31:0] o_total_free,
    output logic [31:0] o_lost_count,
    output logic [31:0] o_lost_bytes
);

    localparam int unsigned IW = $clog2(MAX_REGIONS);
    localparam int unsigned CW = $clog2(MAX_REGIONS + 1);
    localparam int unsigned SW = 32 + CW;
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_REGIONS);
    localparam logic [CW-1:0] CNT_ONE = CW'(1);

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_AUPD, S_FUPD, S_SHDN, S_SHUP, S_INS, S_RESP
    } t_state;

    t_state          r_st;
    logic            r_alloc;
    logic [31:0]     r_addr;
    logic [31:0]     r_size;
    logic [CW-1:0]   r_count;
    logic [SW-1:0]   r_sum;
    logic [31:0]     r_lost_cnt;
    logic [31:0]     r_lost_bytes;
    logic [CW-1:0]   r_rd_idx;
    logic            r_pv;
    logic [CW-1:0]   r_pidx;
    logic [CW-1:0]   r_i;
    logic [31:0]     r_prev_s;
    logic [31:0]     r_prev_l;
    logic [31:0]     r_cur_s;
    logic [31:0]     r_cur_l;
    logic            r_has_cur;
    logic [31:0]     r_result;
    logic [1:0]      r_status;
    logic            r_ovld;
    logic [31:0]     r_o_addr;
    logic [1:0]      r_o_status;
    logic [31:0]     r_o_total;
    logic [31:0]     r_o_lcnt;
    logic [31:0]     r_o_lbytes;

    logic            rd_en;
    logic [IW-1:0]   rd_addr;
    logic            wr_en;
    logic [IW-1:0]   wr_addr;
    ffa_pkg::t_entry wr_data;
    ffa_pkg::t_entry rd_data;

    logic [31:0] in_size;
    logic [31:0] end_addr;
    logic [31:0] a_newlen;
    logic [31:0] f_len1;
    logic [31:0] f_len2;
    logic [31:0] f_nlen;
    logic        prev_m;
    logic        next_m;
    logic        hit;
    logic        scan_end;
    logic        shdn_end;
    logic        shup_end;
    logic [CW-1:0] up_src;

    ffa_table #(
        .DEPTH (MAX_REGIONS),
        .AW    (IW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    assign in_size  = (i_req_type == ffa_pkg::REQ_ALLOC_4K || i_req_type == ffa_pkg::REQ_FREE_4K)
                    ? ((i_region_size + ffa_pkg::ROUND_ADD) & ffa_pkg::ROUND_MASK)
                    : i_region_size;
    assign end_addr = r_addr + r_size;
    assign a_newlen = r_cur_l - r_size;
    assign f_len1   = r_prev_l + r_size;
    assign f_len2   = f_len1 + r_cur_l;
    assign f_nlen   = r_cur_l + r_size;
    assign prev_m   = (r_i != '0) && ((r_prev_s + r_prev_l) == r_addr);
    assign next_m   = r_has_cur && (r_cur_s == end_addr);
    assign hit      = r_pv && (r_alloc ? (rd_data.len >= r_size) : (rd_data.start > r_addr));
    assign scan_end = !r_pv && (r_rd_idx >= r_count);
    assign shdn_end = !r_pv && (r_rd_idx >= r_count);
    assign shup_end = !r_pv && (r_rd_idx <= r_i);
    assign up_src   = r_rd_idx - CNT_ONE;

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_rd_idx[IW-1:0];
        wr_en   = 1'b0;
        wr_addr = r_i[IW-1:0];
        wr_data = '{start: r_addr, len: r_size};
        unique case (r_st)
            S_SCAN: begin
                rd_en = r_rd_idx < r_count;
            end
            S_AUPD: begin
                wr_en   = a_newlen != '0;
                wr_data = '{start: r_cur_s + r_size, len: a_newlen};
            end
            S_FUPD: begin
                if (prev_m) begin
                    wr_en   = 1'b1;
                    wr_addr = IW'(r_i - CNT_ONE);
                    wr_data = '{start: r_prev_s, len: next_m ? f_len2 : f_len1};
                end else if (next_m) begin
                    wr_en   = 1'b1;
                    wr_data = '{start: r_addr, len: f_nlen};
                end
            end
            S_SHDN: begin
                rd_en   = r_rd_idx < r_count;
                wr_en   = r_pv;
                wr_addr = IW'(r_pidx - CNT_ONE);
                wr_data = rd_data;
            end
            S_SHUP: begin
                rd_en   = r_rd_idx > r_i;
                rd_addr = up_src[IW-1:0];
                wr_en   = r_pv;
                wr_addr = IW'(r_pidx + CNT_ONE);
                wr_data = rd_data;
            end
            S_INS: begin
                wr_en = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st         <= S_IDLE;
            r_count      <= '0;
            r_sum        <= '0;
            r_lost_cnt   <= '0;
            r_lost_bytes <= '0;
            r_pv         <= 1'b0;
            r_ovld       <= 1'b0;
        end else begin
            if (r_ovld && !i_out_stall && r_st != S_RESP) begin
                r_ovld <= 1'b0;
            end
            unique case (r_st)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_alloc   <= !i_req_type[0];
                        r_addr    <= i_region_addr;
                        r_size    <= in_size;
                        r_rd_idx  <= '0;
                        r_pv      <= 1'b0;
                        r_status  <= ffa_pkg::ST_OK;
                        r_result  <= '0;
                        r_has_cur <= 1'b0;
                        r_st      <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_pv   <= rd_en;
                    r_pidx <= r_rd_idx;
                    if (rd_en) begin
                        r_rd_idx <= r_rd_idx + CNT_ONE;
                    end
                    if (hit) begin
                        r_i       <= r_pidx;
                        r_cur_s   <= rd_data.start;
                        r_cur_l   <= rd_data.len;
                        r_has_cur <= 1'b1;
                        r_pv      <= 1'b0;
                        r_st      <= r_alloc ? S_AUPD : S_FUPD;
                    end else if (r_pv) begin
                        r_prev_s <= rd_data.start;
                        r_prev_l <= rd_data.len;
                    end else if (scan_end) begin
                        r_i <= r_count;
                        if (r_alloc) begin
                            r_status <= ffa_pkg::ST_NOFIT;
                            r_st     <= S_RESP;
                        end else begin
                            r_st <= S_FUPD;
                        end
                    end
                end
                S_AUPD: begin
                    r_result <= r_cur_s;
                    r_sum    <= r_sum - SW'(r_size);
                    if (a_newlen == '0) begin
                        r_rd_idx <= r_i + CNT_ONE;
                        r_st     <= S_SHDN;
                    end else begin
                        r_st <= S_RESP;
                    end
                end
                S_FUPD: begin
                    if (prev_m) begin
                        if (next_m) begin
                            r_sum    <= r_sum + SW'(f_len2) - SW'(r_prev_l) - SW'(r_cur_l);
                            r_rd_idx <= r_i + CNT_ONE;
                            r_st     <= S_SHDN;
                        end else begin
                            r_sum <= r_sum + SW'(f_len1) - SW'(r_prev_l);
                            r_st  <= S_RESP;
                        end
                    end else if (next_m) begin
                        r_sum <= r_sum + SW'(f_nlen) - SW'(r_cur_l);
                        r_st  <= S_RESP;
                    end else if (r_count < CNT_MAX) begin
                        r_rd_idx <= r_count;
                        r_st     <= S_SHUP;
                    end else begin
                        r_lost_cnt   <= r_lost_cnt + 32'd1;
                        r_lost_bytes <= r_lost_bytes + r_size;
                        r_status     <= ffa_pkg::ST_LOST;
                        r_st         <= S_RESP;
                    end
                end
                S_SHDN: begin
                    r_pv   <= rd_en;
                    r_pidx <= r_rd_idx;
                    if (rd_en) begin
                        r_rd_idx <= r_rd_idx + CNT_ONE;
                    end
                    if (shdn_end) begin
                        r_count <= r_count - CNT_ONE;
                        r_st    <= S_RESP;
                    end
                end
                S_SHUP: begin
                    r_pv   <= rd_en;
                    r_pidx <= up_src;
                    if (rd_en) begin
                        r_rd_idx <= up_src;
                    end
                    if (shup_end) begin
                        r_st <= S_INS;
                    end
                end
                S_INS: begin
                    r_count <= r_count + CNT_ONE;
                    r_sum   <= r_sum + SW'(r_size);
                    r_st    <= S_RESP;
                end
                S_RESP: begin
                    if (!r_ovld || !i_out_stall) begin
                        r_ovld     <= 1'b1;
                        r_o_addr   <= r_result;
                        r_o_status <= r_status;
                        r_o_total  <= (r_sum[SW-1:32] != '0) ? 32'hffff_ffff : r_sum[31:0];
                        r_o_lcnt   <= r_lost_cnt;
                        r_o_lbytes <= r_lost_bytes;
                        r_st       <= S_IDLE;
                    end
                end
                default: begin
                    r_st <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall   = r_st != S_IDLE;
    assign o_out_valid  = r_ovld;
    assign o_alloc_addr = r_o_addr;
    assign o_status     = r_o_status;
    assign o_total_free = r_o_total;
    assign o_lost_count = r_o_lcnt;
    assign o_lost_bytes = r_o_lbytes;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_MAX)
        else $error("entry count above table depth");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("sequencer not busy after taking a request");

    a_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> o_in_stall)
        else $error("table written while idle");

endmodule

### tb/tb_first_fit_free_list_allocator.sv
// Self-checking testbench for the first-fit free-list allocator with coalescing.
typedef struct {
    logic [31:0] addr;
    logic [1:0]  status;
    logic [31:0] total;
    logic [31:0] lcount;
    logic [31:0] lbytes;
} t_alloc_result;

class alloc_scoreboard;
    localparam int unsigned DEPTH = ffa_pkg::MAX_REGIONS_DEF;

    logic [31:0]   reg_start [DEPTH];
    logic [31:0]   reg_len [DEPTH];
    int unsigned   n_regions;
    logic [31:0]   lost_events;
    logic [31:0]   lost_total;
    t_alloc_result pending[$];
    int unsigned   failures;

    function new();
        n_regions   = 0;
        lost_events = 0;
        lost_total  = 0;
        failures    = 0;
    endfunction

    function void drop_region(int unsigned pos);
        n_regions--;
        for (int unsigned k = pos; k < n_regions; k++) begin
            reg_start[k] = reg_start[k + 1];
            reg_len[k]   = reg_len[k + 1];
        end
    endfunction

    function logic [31:0] carve(logic [31:0] size, output logic [1:0] status);
        logic [31:0] a;
        for (int unsigned i = 0; i < n_regions; i++) begin
            if (reg_len[i] >= size) begin
                a            = reg_start[i];
                reg_start[i] = a + size;
                reg_len[i]   = reg_len[i] - size;
                if (reg_len[i] == 0) drop_region(i);
                status = ffa_pkg::ST_OK;
                return a;
            end
        end
        status = ffa_pkg::ST_NOFIT;
        return 32'd0;
    endfunction

    function logic [1:0] release_region(logic [31:0] addr, logic [31:0] size);
        logic [31:0] stop;
        int unsigned i;
        stop = addr + size;
        for (i = 0; i < n_regions; i++)
            if (reg_start[i] > addr) break;
        if (i > 0 && reg_start[i - 1] + reg_len[i - 1] == addr) begin
            reg_len[i - 1] = reg_len[i - 1] + size;
            if (i < n_regions && reg_start[i] == stop) begin
                reg_len[i - 1] = reg_len[i - 1] + reg_len[i];
                drop_region(i);
            end
            return ffa_pkg::ST_OK;
        end
        if (i < n_regions && reg_start[i] == stop) begin
            reg_start[i] = addr;
            reg_len[i]   = reg_len[i] + size;
            return ffa_pkg::ST_OK;
        end
        if (n_regions < DEPTH) begin
            for (int unsigned j = n_regions; j > i; j--) begin
                reg_start[j] = reg_start[j - 1];
                reg_len[j]   = reg_len[j - 1];
            end
            reg_start[i] = addr;
            reg_len[i]   = size;
            n_regions++;
            return ffa_pkg::ST_OK;
        end
        lost_events = lost_events + 1;
        lost_total  = lost_total + size;
        return ffa_pkg::ST_LOST;
    endfunction

    function void note_request(logic [1:0] kind, logic [31:0] addr, logic [31:0] size);
        t_alloc_result r;
        logic [32:0]   sum;
        if (kind[1]) size = (size + ffa_pkg::ROUND_ADD) & ffa_pkg::ROUND_MASK;
        r.addr = 32'd0;
        if (!kind[0]) r.addr = carve(size, r.status);
        else r.status = release_region(addr, size);
        sum = 33'd0;
        for (int unsigned k = 0; k < n_regions; k++) begin
            sum = sum + reg_len[k];
            if (sum > 33'h0_ffff_ffff) sum = 33'h0_ffff_ffff;
        end
        r.total  = sum[31:0];
        r.lcount = lost_events;
        r.lbytes = lost_total;
        pending.push_back(r);
    endfunction

    function void check_result(t_alloc_result got);
        t_alloc_result e;
        if (pending.size() == 0) begin
            failures++;
            if (failures <= 10) $display("unexpected result addr=%h status=%0d",
                                         got.addr, got.status);
            return;
        end
        e = pending.pop_front();
        if (got.addr !== e.addr || got.status !== e.status || got.total !== e.total ||
            got.lcount !== e.lcount || got.lbytes !== e.lbytes) begin
            failures++;
            if (failures <= 10)
                $display("mismatch exp %h %0d %h %h %h got %h %0d %h %h %h",
                         e.addr, e.status, e.total, e.lcount, e.lbytes,
                         got.addr, got.status, got.total, got.lcount, got.lbytes);
        end
    endfunction
endclass

module tb_first_fit_free_list_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 3_000_000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_req_type;
    logic [31:0] i_region_addr;
    logic [31:0] i_region_size;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [31:0] o_alloc_addr;
    logic [1:0]  o_status;
    logic [31:0] o_total_free;
    logic [31:0] o_lost_count;
    logic [31:0] o_lost_bytes;

    alloc_scoreboard sb;
    int unsigned     results_seen;
    int unsigned     cycles;

    first_fit_free_list_allocator u_top (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    task automatic send_request(input logic [1:0] kind, input logic [31:0] addr,
                                input logic [31:0] size);
        i_in_valid    <= 1'b1;
        i_req_type    <= kind;
        i_region_addr <= addr;
        i_region_size <= size;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_request(kind, addr, size);
    endtask

    task automatic idle_input(input int unsigned n);
        i_in_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_size();
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return $urandom();
            2:       return 32'hffff_ffff;
            default: return $urandom_range(1, 32'h3000);
        endcase
    endfunction

    task automatic random_request(input bit fill);
        logic [1:0]  kind;
        logic [31:0] addr;
        logic [31:0] size;
        int unsigned sel;
        int unsigned idx;
        size = pick_size();
        addr = $urandom();
        sel  = fill ? $urandom_range(0, 59) : $urandom_range(0, 99);
        if (sel < 40) begin
            kind = ffa_pkg::REQ_FREE;
        end else if (sel < 55 && sb.n_regions > 0) begin
            idx  = $urandom_range(0, sb.n_regions - 1);
            kind = ffa_pkg::REQ_FREE;
            addr = sb.reg_start[idx] + sb.reg_len[idx];
        end else if (sel < 65 && sb.n_regions > 0) begin
            idx  = $urandom_range(0, sb.n_regions - 1);
            kind = ffa_pkg::REQ_FREE;
            addr = sb.reg_start[idx] - size;
        end else begin
            kind = ffa_pkg::REQ_ALLOC;
            if (sb.n_regions > 0 && $urandom_range(0, 2) == 0) begin
                idx  = $urandom_range(0, sb.n_regions - 1);
                size = sb.reg_len[idx];
            end
        end
        if ($urandom_range(0, 3) == 0) kind = kind | ffa_pkg::REQ_ALLOC_4K;
        send_request(kind, addr, size);
    endtask

    initial begin
        int unsigned stall_pct;
        stall_pct    = 0;
        results_seen = 0;
        i_out_stall  = 1'b1;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (o_out_valid && !i_out_stall) begin
                sb.check_result('{o_alloc_addr, o_status, o_total_free,
                                  o_lost_count, o_lost_bytes});
                results_seen++;
            end
            if (results_seen == 150) begin
                i_out_stall <= 1'b1;
                repeat (4000) @(posedge i_clk);
                results_seen++;
            end
            if (cycles % 300 == 0) stall_pct = $urandom_range(0, 3) * 25;
            i_out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    initial begin
        int unsigned sent;
        int unsigned burst;
        sb            = new();
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_req_type    = ffa_pkg::REQ_ALLOC;
        i_region_addr = 32'd0;
        i_region_size = 32'd0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(ffa_pkg::REQ_ALLOC, 32'hffff_ffff, 32'd16);
        send_request(ffa_pkg::REQ_ALLOC, 32'd0, 32'd0);
        send_request(ffa_pkg::REQ_FREE, 32'd0, 32'h1000);
        send_request(ffa_pkg::REQ_ALLOC, 32'd0, 32'h10);
        send_request(ffa_pkg::REQ_FREE, 32'h5000, 32'd0);
        send_request(ffa_pkg::REQ_ALLOC, 32'd0, 32'd0);
        send_request(ffa_pkg::REQ_FREE, 32'h2_0000, 32'h100);
        send_request(ffa_pkg::REQ_FREE, 32'h2_0200, 32'h100);
        send_request(ffa_pkg::REQ_FREE, 32'h2_0100, 32'h100);
        send_request(ffa_pkg::REQ_FREE, 32'h1_ff00, 32'h100);
        send_request(ffa_pkg::REQ_FREE, 32'hffff_f000, 32'h2000);
        send_request(ffa_pkg::REQ_FREE_4K, 32'h4000_0000, 32'hffff_ffff);
        send_request(ffa_pkg::REQ_FREE_4K, 32'h5000_0000, 32'd1);
        send_request(ffa_pkg::REQ_ALLOC_4K, 32'd0, 32'd1);
        send_request(ffa_pkg::REQ_ALLOC_4K, 32'd0, 32'hffff_ffff);
        send_request(ffa_pkg::REQ_FREE, 32'h8000_0000, 32'hffff_ffff);
        send_request(ffa_pkg::REQ_ALLOC, 32'd0, 32'hffff_ffff);
        send_request(ffa_pkg::REQ_ALLOC, 32'd0, 32'hffff_ffff);
        send_request(ffa_pkg::REQ_FREE, 32'h7fff_ffff, 32'd1);
        send_request(ffa_pkg::REQ_ALLOC, 32'd0, 32'h8000_0000);

        sent = 0;
        while (sent < 700) begin
            burst = $urandom_range(1, 20);
            repeat (burst) begin
                random_request(sent < 330);
                sent++;
            end
            if (sent >= 500 && sent < 520) begin
                i_in_valid <= 1'b0;
                while (sb.pending.size() != 0) @(posedge i_clk);
            end
            if ($urandom_range(0, 3) != 0) idle_input($urandom_range(1, 6));
        end
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
        if (sb.failures == 0 && sb.pending.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
